[rtl/tlbm_pkg.sv]
// shared types, constants and helper functions of the three-lamp blink mode controller
package tlbm_pkg;

    localparam int NUM_LAMPS_DEF  = 3;
    localparam int TIME_WIDTH_DEF = 32;

    // lamps visible on the result channel
    localparam int OUT_LAMPS = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int NOW_W     = 32;
    localparam int TRAFFIC_W = 16;
    localparam int LEVEL_W   = 12;
    localparam int MODE_W    = 3;
    localparam int VALUE_W   = 8;
    localparam int COUNT_W   = 4;
    localparam int SPAN_W    = 24;
    localparam int GPER_W    = 10;

    localparam logic [15:0]        MS_PER_MINUTE = 16'd60000;
    localparam logic [VALUE_W-1:0] AUTO_VALUE    = 8'd100;
    localparam logic [SPAN_W-1:0]  DEF_SPAN_MS   = 24'd60000;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD_LOW   = 3'd0,
        REG_THRESHOLD_HIGH  = 3'd1,
        REG_AUTO_PERIOD     = 3'd2,
        REG_MANUAL_TIMEOUT  = 3'd3,
        REG_MANUAL_START    = 3'd4,
        REG_MANUAL_ENABLE   = 3'd5,
        REG_MANUAL_MODES    = 3'd6,
        REG_MANUAL_LEVELS   = 3'd7
    } cfg_reg_t;

    // lamp modes
    localparam logic [MODE_W-1:0] MODE_OFF        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STEADY     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BLINK_SLOW = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BLINK_MID  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BLINK_FAST = 3'd4;

    // ticks between toggles, zero when the mode does not blink
    function automatic logic [COUNT_W-1:0] blink_limit(input logic [MODE_W-1:0] mode);
        logic [COUNT_W-1:0] lim;
        case (mode)
            MODE_BLINK_SLOW: lim = 4'd10;
            MODE_BLINK_MID:  lim = 4'd7;
            MODE_BLINK_FAST: lim = 4'd5;
            default:         lim = 4'd0;
        endcase
        return lim;
    endfunction

    // green indicator half period in ms, zero when it does not blink
    function automatic logic [GPER_W-1:0] green_period(input logic [MODE_W-1:0] mode);
        logic [GPER_W-1:0] per;
        case (mode)
            MODE_BLINK_SLOW: per = 10'd1000;
            MODE_BLINK_MID:  per = 10'd500;
            MODE_BLINK_FAST: per = 10'd250;
            default:         per = 10'd0;
        endcase
        return per;
    endfunction

    // value times ten as two shifts
    function automatic logic [LEVEL_W-1:0] level_of(input logic [VALUE_W-1:0] v);
        return LEVEL_W'({v, 3'b000}) + LEVEL_W'({v, 1'b0});
    endfunction

endpackage

[rtl/tlbm_if.sv]
// valid/ready channel interfaces for control ticks and lamp results
interface tlbm_tick_if;
    logic                            valid;
    logic                            ready;
    logic [tlbm_pkg::NOW_W-1:0]      now_ms;
    logic [tlbm_pkg::TRAFFIC_W-1:0]  traffic_count;

    modport source (output valid, output now_ms, output traffic_count, input ready);
    modport sink   (input valid, input now_ms, input traffic_count, output ready);
endinterface

interface tlbm_result_if;
    logic                          valid;
    logic                          ready;
    logic [tlbm_pkg::LEVEL_W-1:0]  lamp0_level;
    logic [tlbm_pkg::LEVEL_W-1:0]  lamp1_level;
    logic [tlbm_pkg::LEVEL_W-1:0]  lamp2_level;
    logic                          green_led;
    logic                          manual_active;

    modport source (output valid, output lamp0_level, output lamp1_level,
                    output lamp2_level, output green_led, output manual_active,
                    input ready);
    modport sink   (input valid, input lamp0_level, input lamp1_level,
                    input lamp2_level, input green_led, input manual_active,
                    output ready);
endinterface

[rtl/three_lamp_blink_mode_controller_top.sv]
// three-lamp blink mode controller: tick register, single-pass update, result register
// a transferred tick passes the tick register, then the result register (two register stages)
// throughput: one tick per cycle while the result side keeps ready high
// the tick register and the result register part the two sides, so an empty tick register
// takes a new tick while a finished result still waits for its transfer
// reset: async active low; lamps dark, counters zero, lamp zero in fast auto blink,
// period and timeout one minute, thresholds zero, manual mode disabled
module three_lamp_blink_mode_controller_top #(
    parameter int NUM_LAMPS  = tlbm_pkg::NUM_LAMPS_DEF,
    parameter int TIME_WIDTH = tlbm_pkg::TIME_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tlbm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlbm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    tlbm_tick_if.sink                         tick,
    tlbm_result_if.source                     result
);

    // compare width covers both the time difference and a span of up to 255 minutes
    localparam int CMP_W = (TIME_WIDTH > tlbm_pkg::SPAN_W) ? TIME_WIDTH : tlbm_pkg::SPAN_W;
    // lamp one takes the threshold-high class; with only one lamp the index is zero and unused
    localparam int LAMP1 = (NUM_LAMPS > 1) ? 1 : 0;

    // configuration registers (spans kept in ms, multiplied at write time)
    logic [tlbm_pkg::TRAFFIC_W-1:0] thr_low_reg;
    logic [tlbm_pkg::TRAFFIC_W-1:0] thr_high_reg;
    logic [tlbm_pkg::SPAN_W-1:0]    period_ms_reg;
    logic [tlbm_pkg::SPAN_W-1:0]    timeout_ms_reg;
    logic [tlbm_pkg::NOW_W-1:0]     manual_start_reg;
    logic                           manual_enable_reg;
    logic [3*tlbm_pkg::MODE_W-1:0]  manual_modes_reg;
    logic [3*tlbm_pkg::VALUE_W-1:0] manual_levels_reg;

    // tick register stage
    logic                           s1_valid_reg;
    logic [tlbm_pkg::NOW_W-1:0]     s1_now_reg;
    logic [tlbm_pkg::TRAFFIC_W-1:0] s1_traffic_reg;
    logic                           s1_fire;

    // controller state
    logic [tlbm_pkg::LEVEL_W-1:0]   level_reg      [NUM_LAMPS];
    logic [tlbm_pkg::LEVEL_W-1:0]   level_next     [NUM_LAMPS];
    logic [tlbm_pkg::COUNT_W-1:0]   count_reg      [NUM_LAMPS];
    logic [tlbm_pkg::COUNT_W-1:0]   count_next     [NUM_LAMPS];
    logic [tlbm_pkg::MODE_W-1:0]    auto_mode_reg  [NUM_LAMPS];
    logic [tlbm_pkg::MODE_W-1:0]    auto_mode_next [NUM_LAMPS];
    logic [tlbm_pkg::MODE_W-1:0]    mode_w         [NUM_LAMPS];
    logic [TIME_WIDTH-1:0]          last_reclass_reg;
    logic [TIME_WIDTH-1:0]          last_reclass_next;
    logic [TIME_WIDTH-1:0]          last_green_reg;
    logic [TIME_WIDTH-1:0]          last_green_next;
    logic                           green_reg;
    logic                           green_next;
    logic                           expired_reg;
    logic                           expired_next;

    // result register stage
    logic                           out_valid_reg;
    logic [tlbm_pkg::LEVEL_W-1:0]   out_level_reg  [tlbm_pkg::OUT_LAMPS];
    logic [tlbm_pkg::LEVEL_W-1:0]   out_level_next [tlbm_pkg::OUT_LAMPS];
    logic                           out_green_reg;
    logic                           out_manual_reg;

    // per-tick working signals
    logic [TIME_WIDTH-1:0]          now_tw;
    logic [TIME_WIDTH-1:0]          start_tw;
    logic [TIME_WIDTH-1:0]          diff_reclass;
    logic [TIME_WIDTH-1:0]          diff_manual;
    logic [TIME_WIDTH-1:0]          diff_green;
    logic                           reclass;
    logic                           manual;
    logic [tlbm_pkg::MODE_W-1:0]    top_mode;
    logic [tlbm_pkg::GPER_W-1:0]    gper;

    // ---------------- handshake ----------------
    // the update fires when the result register is empty or being drained
    assign s1_fire    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            s1_valid_reg <= tick.valid;
        end
    end

    // tick payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            s1_now_reg     <= tick.now_ms;
            s1_traffic_reg <= tick.traffic_count;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_low_reg       <= '0;
            thr_high_reg      <= '0;
            period_ms_reg     <= tlbm_pkg::DEF_SPAN_MS;
            timeout_ms_reg    <= tlbm_pkg::DEF_SPAN_MS;
            manual_start_reg  <= '0;
            manual_enable_reg <= 1'b0;
            manual_modes_reg  <= '0;
            manual_levels_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (tlbm_pkg::cfg_reg_t'(cfg_index))
                tlbm_pkg::REG_THRESHOLD_LOW:
                    thr_low_reg <= cfg_wdata[tlbm_pkg::TRAFFIC_W-1:0];
                tlbm_pkg::REG_THRESHOLD_HIGH:
                    thr_high_reg <= cfg_wdata[tlbm_pkg::TRAFFIC_W-1:0];
                tlbm_pkg::REG_AUTO_PERIOD:
                    period_ms_reg <= tlbm_pkg::SPAN_W'(cfg_wdata[7:0])
                                     * tlbm_pkg::SPAN_W'(tlbm_pkg::MS_PER_MINUTE);
                tlbm_pkg::REG_MANUAL_TIMEOUT:
                    timeout_ms_reg <= tlbm_pkg::SPAN_W'(cfg_wdata[7:0])
                                      * tlbm_pkg::SPAN_W'(tlbm_pkg::MS_PER_MINUTE);
                tlbm_pkg::REG_MANUAL_START:
                    manual_start_reg <= cfg_wdata[tlbm_pkg::NOW_W-1:0];
                tlbm_pkg::REG_MANUAL_ENABLE:
                    manual_enable_reg <= cfg_wdata[0];
                tlbm_pkg::REG_MANUAL_MODES:
                    manual_modes_reg <= cfg_wdata[3*tlbm_pkg::MODE_W-1:0];
                tlbm_pkg::REG_MANUAL_LEVELS:
                    manual_levels_reg <= cfg_wdata[3*tlbm_pkg::VALUE_W-1:0];
            endcase
        end
    end

    // ---------------- timing compares ----------------
    // the timestamp is 32 bits wide and wraps within the time width
    assign now_tw   = TIME_WIDTH'({32'b0, s1_now_reg});
    assign start_tw = TIME_WIDTH'({32'b0, manual_start_reg});

    assign diff_reclass = now_tw - last_reclass_reg;
    assign diff_manual  = now_tw - start_tw;
    assign diff_green   = now_tw - last_green_reg;

    assign reclass = CMP_W'(diff_reclass) > CMP_W'(period_ms_reg);

    // a config write clears expiry; writes only come while idle: a rule for the user, the block does not enforce it
    assign expired_next = expired_reg
                          || (manual_enable_reg && CMP_W'(diff_manual) > CMP_W'(timeout_ms_reg));
    assign manual       = manual_enable_reg && !expired_next;

    assign last_reclass_next = reclass ? now_tw : last_reclass_reg;

    // traffic classification when the period has run out, all other lamps off; modes hold otherwise
    always_comb
    begin
        for (int i = 0; i < NUM_LAMPS; i++)
        begin
            auto_mode_next[i] = reclass ? tlbm_pkg::MODE_OFF : auto_mode_reg[i];
        end
        if (reclass)
        begin
            if (s1_traffic_reg < thr_low_reg)
            begin
                auto_mode_next[0] = tlbm_pkg::MODE_BLINK_SLOW;
            end
            else if (NUM_LAMPS > 1)
            begin
                auto_mode_next[LAMP1] = (s1_traffic_reg < thr_high_reg)
                                        ? tlbm_pkg::MODE_BLINK_MID
                                        : tlbm_pkg::MODE_BLINK_FAST;
            end
        end
    end

    // ---------------- lamp lanes ----------------
    for (genvar g = 0; g < NUM_LAMPS; g++)
    begin : g_lamp
        logic [tlbm_pkg::VALUE_W-1:0] value_w;
        logic [tlbm_pkg::LEVEL_W-1:0] lit_level;
        logic [tlbm_pkg::COUNT_W-1:0] limit;
        logic [tlbm_pkg::COUNT_W-1:0] count_inc;

        // manual registers only cover the first three lamps
        if (g < tlbm_pkg::OUT_LAMPS)
        begin : g_man
            always_comb
            begin
                mode_w[g] = manual ? manual_modes_reg[g*tlbm_pkg::MODE_W +: tlbm_pkg::MODE_W]
                                   : auto_mode_next[g];
                value_w   = manual ? manual_levels_reg[g*tlbm_pkg::VALUE_W +: tlbm_pkg::VALUE_W]
                                   : tlbm_pkg::AUTO_VALUE;
            end
        end
        else
        begin : g_noman
            always_comb
            begin
                mode_w[g] = manual ? tlbm_pkg::MODE_OFF : auto_mode_next[g];
                value_w   = manual ? '0 : tlbm_pkg::AUTO_VALUE;
            end
        end

        assign lit_level = tlbm_pkg::level_of(value_w);
        assign limit     = tlbm_pkg::blink_limit(mode_w[g]);
        assign count_inc = count_reg[g] + 1'b1;

        always_comb
        begin
            level_next[g] = level_reg[g];
            count_next[g] = count_reg[g];
            case (mode_w[g])
                tlbm_pkg::MODE_OFF:    level_next[g] = '0;
                tlbm_pkg::MODE_STEADY: level_next[g] = lit_level;
                default:               level_next[g] = level_reg[g];
            endcase
            // blinking: toggle when the counter reaches the mode's limit
            if (limit != '0)
            begin
                if (count_inc >= limit)
                begin
                    count_next[g] = '0;
                    level_next[g] = (level_reg[g] != '0) ? '0 : lit_level;
                end
                else
                begin
                    count_next[g] = count_inc;
                end
            end
        end
    end

    // ---------------- green indicator ----------------
    always_comb
    begin
        top_mode = tlbm_pkg::MODE_OFF;
        for (int i = 0; i < NUM_LAMPS; i++)
        begin
            if (mode_w[i] > top_mode)
            begin
                top_mode = mode_w[i];
            end
        end
    end

    assign gper = tlbm_pkg::green_period(top_mode);

    always_comb
    begin
        green_next      = green_reg;
        last_green_next = last_green_reg;
        if (top_mode == tlbm_pkg::MODE_STEADY)
        begin
            green_next = 1'b1;
        end
        else if (gper == '0)
        begin
            green_next = 1'b0;
        end
        else if (CMP_W'(diff_green) > CMP_W'(gper))
        begin
            green_next      = !green_reg;
            last_green_next = now_tw;
        end
    end

    // ---------------- state commit ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LAMPS; i++)
            begin
                level_reg[i]     <= '0;
                count_reg[i]     <= '0;
                auto_mode_reg[i] <= tlbm_pkg::MODE_OFF;
            end
            auto_mode_reg[0] <= tlbm_pkg::MODE_BLINK_FAST;
            last_reclass_reg <= '0;
            last_green_reg   <= '0;
            green_reg        <= 1'b0;
            expired_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            // any write to a defined register re-arms manual mode
            expired_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            for (int i = 0; i < NUM_LAMPS; i++)
            begin
                level_reg[i]     <= level_next[i];
                count_reg[i]     <= count_next[i];
                auto_mode_reg[i] <= auto_mode_next[i];
            end
            last_reclass_reg <= last_reclass_next;
            last_green_reg   <= last_green_next;
            green_reg        <= green_next;
            expired_reg      <= expired_next;
        end
    end

    // ---------------- result register ----------------
    for (genvar g = 0; g < tlbm_pkg::OUT_LAMPS; g++)
    begin : g_out
        if (g < NUM_LAMPS)
        begin : g_used
            assign out_level_next[g] = level_next[g];
        end
        else
        begin : g_unused
            assign out_level_next[g] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            for (int i = 0; i < tlbm_pkg::OUT_LAMPS; i++)
            begin
                out_level_reg[i] <= out_level_next[i];
            end
            out_green_reg  <= green_next;
            out_manual_reg <= manual;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.lamp0_level   = out_level_reg[0];
    assign result.lamp1_level   = out_level_reg[1];
    assign result.lamp2_level   = out_level_reg[2];
    assign result.green_led     = out_green_reg;
    assign result.manual_active = out_manual_reg;

endmodule

[rtl/tlbm_checker.sv]
// port-level assertions for the three-lamp blink mode controller, bound to the top level
module tlbm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         tick_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [tlbm_pkg::LEVEL_W-1:0] lamp0_level,
    input logic [tlbm_pkg::LEVEL_W-1:0] lamp1_level,
    input logic [tlbm_pkg::LEVEL_W-1:0] lamp2_level,
    input logic                         green_led,
    input logic                         manual_active
);

    localparam logic [tlbm_pkg::LEVEL_W-1:0] MAX_LEVEL = 12'd2550;

    // a stalled result keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(lamp0_level)
            && $stable(lamp1_level) && $stable(lamp2_level)
            && $stable(green_led) && $stable(manual_active))
        else $error("stalled result changed");

    // a draining result side never blocks ticks
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        res_ready |-> tick_ready)
        else $error("tick side stalled while result side is ready");

    // drive never exceeds value 255 times ten
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> lamp0_level <= MAX_LEVEL && lamp1_level <= MAX_LEVEL
            && lamp2_level <= MAX_LEVEL)
        else $error("lamp level out of range");

    // auto classification never lights lamp two
    a_auto_lamp2: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !manual_active |-> lamp2_level == '0)
        else $error("lamp two lit in auto mode");

endmodule

bind three_lamp_blink_mode_controller_top tlbm_checker u_tlbm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_ready    (tick.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .lamp0_level   (result.lamp0_level),
    .lamp1_level   (result.lamp1_level),
    .lamp2_level   (result.lamp2_level),
    .green_led     (result.green_led),
    .manual_active (result.manual_active)
);

[test/tb_three_lamp_blink_mode_controller_top.sv]
// self-checking testbench of the three-lamp blink mode controller: directed table, then random ticks
`timescale 1ns / 100ps

module tb_three_lamp_blink_mode_controller_top;

    import tlbm_pkg::*;

    // generous bound on the length of the whole run
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES      = 8;
    localparam int PHASE_TICKS = 117;
    localparam int DIR_ROWS    = 31;

    // one lamp result as it leaves the block
    typedef struct packed {
        logic [LEVEL_W-1:0] lamp0;
        logic [LEVEL_W-1:0] lamp1;
        logic [LEVEL_W-1:0] lamp2;
        logic               green;
        logic               manual;
    } lamp_result_t;

    typedef enum bit {ROW_TICK, ROW_WRITE} row_kind_t;

    // a directed row is either a register write or a tick; typed holds the
    // result written out by hand when known is set
    typedef struct packed {
        row_kind_t          kind;
        cfg_reg_t           setting;
        logic [31:0]        data;
        logic [NOW_W-1:0]   now;
        logic [TRAFFIC_W-1:0] traffic;
        bit                 known;
        lamp_result_t       typed;
    } dir_row_t;

    localparam lamp_result_t DARK = '0;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // after reset lamp zero blinks fast: dark for four ticks, lit on the fifth
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd0, 16'd0, 1'b1, DARK},
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd0, 16'd0, 1'b1, DARK},
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd0, 16'd0, 1'b1, DARK},
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd0, 16'd0, 1'b1, DARK},
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd0, 16'd0, 1'b1,
          '{12'd1000, 12'd0, 12'd0, 1'b0, 1'b0}},
        // green flips once more than 250 ms have passed
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd251, 16'd0, 1'b1,
          '{12'd1000, 12'd0, 12'd0, 1'b1, 1'b0}},
        // one minute passed: reclassified, lamp one takes over the fast blink
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd60001, 16'd0, 1'b1, DARK},
        // largest timestamp and traffic, then the time wraps to zero
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
          '{12'd0, 12'd0, 12'd0, 1'b1, 1'b0}},
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd0, 16'd0, 1'b1,
          '{12'd0, 12'd0, 12'd0, 1'b1, 1'b0}},
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd0, 16'd0, 1'b1,
          '{12'd0, 12'd0, 12'd0, 1'b1, 1'b0}},
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd0, 16'd0, 1'b1,
          '{12'd0, 12'd1000, 12'd0, 1'b1, 1'b0}},
        // zero period: every tick with a nonzero time step reclassifies
        '{ROW_WRITE, REG_THRESHOLD_LOW,  32'd100, 32'd0, 16'd0, 1'b0, DARK},
        '{ROW_WRITE, REG_THRESHOLD_HIGH, 32'd200, 32'd0, 16'd0, 1'b0, DARK},
        '{ROW_WRITE, REG_AUTO_PERIOD,    32'd0,   32'd0, 16'd0, 1'b0, DARK},
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd5,  16'd50,    1'b0, DARK},
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd10, 16'd150,   1'b0, DARK},
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd20, 16'd200,   1'b0, DARK},
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd30, 16'hFFFF,  1'b0, DARK},
        // manual: steady lamps at value one and at the largest value, lamp one frozen
        '{ROW_WRITE, REG_MANUAL_LEVELS,  32'hFF8001, 32'd0, 16'd0, 1'b0, DARK},
        '{ROW_WRITE, REG_MANUAL_MODES,   32'd121,    32'd0, 16'd0, 1'b0, DARK},
        '{ROW_WRITE, REG_MANUAL_TIMEOUT, 32'd255,    32'd0, 16'd0, 1'b0, DARK},
        '{ROW_WRITE, REG_MANUAL_START,   32'd0,      32'd0, 16'd0, 1'b0, DARK},
        '{ROW_WRITE, REG_MANUAL_ENABLE,  32'd1,      32'd0, 16'd0, 1'b0, DARK},
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd40, 16'd0, 1'b0, DARK},
        // just past the longest timeout: manual mode expires
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd15300041, 16'd0, 1'b0, DARK},
        // a config write revives it; modes five and six freeze lamps zero and one, green goes dark
        '{ROW_WRITE, REG_MANUAL_MODES,   32'd245,    32'd0, 16'd0, 1'b0, DARK},
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd100, 16'd0, 1'b0, DARK},
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd100, 16'd0, 1'b0, DARK},
        // zero timeout: expires as soon as any time has passed since the start
        '{ROW_WRITE, REG_MANUAL_TIMEOUT, 32'd0,      32'd0, 16'd0, 1'b0, DARK},
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd100, 16'd0, 1'b0, DARK},
        '{ROW_TICK,  REG_THRESHOLD_LOW, 32'd0, 32'd100, 16'd0, 1'b0, DARK}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    tlbm_tick_if   tick_ch ();
    tlbm_result_if result_ch ();

    three_lamp_blink_mode_controller_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .tick      (tick_ch),
        .result    (result_ch)
    );

    // settings as the block holds them, reset values included
    logic [15:0] set_thr_low   = '0;
    logic [15:0] set_thr_high  = '0;
    logic [7:0]  set_period    = 8'd1;
    logic [7:0]  set_timeout   = 8'd1;
    logic [31:0] set_start     = '0;
    logic        set_enable    = 1'b0;
    logic [8:0]  set_modes     = '0;
    logic [23:0] set_levels    = '0;

    // controller state of the predictor
    logic [LEVEL_W-1:0] ctl_level [3]     = '{default: '0};
    logic [COUNT_W-1:0] ctl_blink [3]     = '{default: '0};
    logic [MODE_W-1:0]  ctl_auto_mode [3] = '{MODE_BLINK_FAST, MODE_OFF, MODE_OFF};
    logic [31:0]        ctl_last_reclass  = '0;
    logic [31:0]        ctl_last_green    = '0;
    logic               ctl_green         = 1'b0;
    logic               ctl_expired       = 1'b0;

    lamp_result_t lamp_expect_q [$];
    int           fail_count  = 0;
    int           cycle_count = 0;
    bit           steady_flow = 1'b0;   // both sides without idle cycles

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // overall watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[three_lamp_blink_mode_controller_top] ERROR");
            $finish;
        end
    end

    // one control tick of the controller: updates the state, returns the result
    function automatic lamp_result_t advance_controller(input logic [31:0] now,
                                                        input logic [15:0] traffic);
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] value;
        logic [MODE_W-1:0]  top;
        logic [COUNT_W-1:0] limit;
        logic [10:0]        half_ms;
        logic               manual;
        top = MODE_OFF;
        // traffic reclassification once the control period has run out
        if ((now - ctl_last_reclass) > 32'(set_period) * 32'(MS_PER_MINUTE))
        begin
            ctl_last_reclass = now;
            ctl_auto_mode = '{MODE_OFF, MODE_OFF, MODE_OFF};
            if (traffic < set_thr_low)
                ctl_auto_mode[0] = MODE_BLINK_SLOW;
            else
                ctl_auto_mode[1] = (traffic < set_thr_high) ? MODE_BLINK_MID : MODE_BLINK_FAST;
        end
        if (set_enable && !ctl_expired &&
            (now - set_start) > 32'(set_timeout) * 32'(MS_PER_MINUTE))
            ctl_expired = 1'b1;
        manual = set_enable && !ctl_expired;
        for (int i = 0; i < 3; i++)
        begin
            mode  = manual ? set_modes[3*i +: 3] : ctl_auto_mode[i];
            value = manual ? set_levels[8*i +: 8] : AUTO_VALUE;
            limit = '0;
            case (mode)
                MODE_OFF:        ctl_level[i] = '0;
                MODE_STEADY:     ctl_level[i] = 12'(value) * 12'd10;
                MODE_BLINK_SLOW: limit = 4'd10;
                MODE_BLINK_MID:  limit = 4'd7;
                MODE_BLINK_FAST: limit = 4'd5;
                default:         limit = '0;    // modes five to seven freeze the lamp
            endcase
            // the blink counter survives mode changes, so it may already be past the limit
            if (limit != 0)
            begin
                ctl_blink[i] = ctl_blink[i] + 4'd1;
                if (ctl_blink[i] >= limit)
                begin
                    ctl_blink[i] = '0;
                    ctl_level[i] = (ctl_level[i] != 0) ? '0 : 12'(value) * 12'd10;
                end
            end
            if (mode > top)
                top = mode;
        end
        // green indicator follows the highest lamp mode
        case (top)
            MODE_BLINK_SLOW: half_ms = 11'd1000;
            MODE_BLINK_MID:  half_ms = 11'd500;
            MODE_BLINK_FAST: half_ms = 11'd250;
            default:         half_ms = 11'd0;
        endcase
        if (top == MODE_STEADY)
            ctl_green = 1'b1;
        else if (half_ms == 0)
            ctl_green = 1'b0;
        else if ((now - ctl_last_green) > 32'(half_ms))
        begin
            ctl_last_green = now;
            ctl_green = ~ctl_green;
        end
        return '{ctl_level[0], ctl_level[1], ctl_level[2], ctl_green, manual};
    endfunction

    // stop sending and wait until every expected result has been transferred
    task automatic wait_idle();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (lamp_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_setting(input cfg_reg_t setting, input logic [31:0] data);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= setting;
        cfg_wdata <= data;
        @(posedge clk);
        case (setting)
            REG_THRESHOLD_LOW:  set_thr_low  = data[15:0];
            REG_THRESHOLD_HIGH: set_thr_high = data[15:0];
            REG_AUTO_PERIOD:    set_period   = data[7:0];
            REG_MANUAL_TIMEOUT: set_timeout  = data[7:0];
            REG_MANUAL_START:   set_start    = data;
            REG_MANUAL_ENABLE:  set_enable   = data[0];
            REG_MANUAL_MODES:   set_modes    = data[8:0];
            REG_MANUAL_LEVELS:  set_levels   = data[23:0];
            default:            ;
        endcase
        // any write clears the expiry
        ctl_expired = 1'b0;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // offer one tick after a random gap; the expectation is queued at its transfer
    task automatic send_tick(input logic [31:0] now, input logic [15:0] traffic,
                             input bit known, input lamp_result_t typed);
        int           gap;
        lamp_result_t predicted;
        gap = steady_flow ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap != 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_ch.valid         <= 1'b1;
        tick_ch.now_ms        <= now;
        tick_ch.traffic_count <= traffic;
        do
            @(posedge clk);
        while (tick_ch.ready !== 1'b1);
        predicted = advance_controller(now, traffic);
        lamp_expect_q.push_back(known ? typed : predicted);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // result side: random stalls, then compare each transfer with the oldest expectation
    initial
    begin
        int           stall;
        lamp_result_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 8);
            @(negedge clk);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (result_ch.valid !== 1'b1);
            if (lamp_expect_q.size() == 0)
            begin
                $display("%0t ns: result transfer with no expectation pending", $time);
                fail_count++;
            end
            else
            begin
                want = lamp_expect_q.pop_front();
                check_field("lamp0_level", want.lamp0, result_ch.lamp0_level);
                check_field("lamp1_level", want.lamp1, result_ch.lamp1_level);
                check_field("lamp2_level", want.lamp2, result_ch.lamp2_level);
                check_field("green_led", want.green, result_ch.green_led);
                check_field("manual_active", want.manual, result_ch.manual_active);
            end
        end
    end

    // stimulus
    initial
    begin
        logic [31:0] clock_ms;
        logic [15:0] traffic;
        logic [15:0] w_low;
        logic [15:0] w_high;
        logic [7:0]  w_period;
        logic [7:0]  w_timeout;
        logic [31:0] w_start;
        logic        w_enable;
        logic [8:0]  w_modes;
        logic [23:0] w_levels;
        int          sel;
        int          near_val;

        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = REG_THRESHOLD_LOW;
        cfg_wdata             = '0;
        tick_ch.valid         = 1'b0;
        tick_ch.now_ms        = '0;
        tick_ch.traffic_count = '0;
        result_ch.ready       = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        foreach (DIRECTED[r])
        begin
            if (DIRECTED[r].kind == ROW_WRITE)
                write_setting(DIRECTED[r].setting, DIRECTED[r].data);
            else
                send_tick(DIRECTED[r].now, DIRECTED[r].traffic, DIRECTED[r].known,
                          DIRECTED[r].typed);
        end
        clock_ms = 32'd100;

        // random phases, each under its own settings
        for (int phase = 0; phase < PHASES; phase++)
        begin
            steady_flow = (phase % 3 == 2);
            w_low     = 16'($urandom_range(0, 65535));
            w_high    = 16'($urandom_range(0, 65535));
            w_period  = 8'($urandom_range(0, 2));
            w_timeout = 8'($urandom_range(0, 2));
            w_enable  = 1'($urandom_range(0, 1));
            w_start   = clock_ms - 32'($urandom_range(0, 30000));
            w_levels  = 24'($urandom);
            // mostly modes that are off, light or blink, now and then the freezing ones
            for (int k = 0; k < 3; k++)
                w_modes[3*k +: 3] = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                                 : 3'($urandom_range(0, 4));
            case (phase)
                0:
                begin
                    w_low = '0; w_high = '0; w_period = '0; w_timeout = '0; w_enable = 1'b0;
                end
                1:
                begin
                    w_low = 16'hFFFF; w_high = 16'hFFFF; w_period = 8'hFF; w_timeout = 8'hFF;
                    w_enable = 1'b1; w_levels = 24'hFFFFFF; w_start = clock_ms;
                end
                2:
                begin
                    w_enable = 1'b1; w_levels = '0; w_timeout = '0; w_start = clock_ms;
                end
                3:
                begin
                    // run across the wrap of the millisecond counter
                    clock_ms = 32'hFFFF_0000 + 32'($urandom_range(0, 65535));
                    w_enable = 1'b1; w_start = clock_ms;
                end
                4:
                    w_start = $urandom;
                default: ;
            endcase
            write_setting(REG_THRESHOLD_LOW, 32'(w_low));
            write_setting(REG_THRESHOLD_HIGH, 32'(w_high));
            write_setting(REG_AUTO_PERIOD, 32'(w_period));
            write_setting(REG_MANUAL_TIMEOUT, 32'(w_timeout));
            write_setting(REG_MANUAL_START, w_start);
            write_setting(REG_MANUAL_MODES, 32'(w_modes));
            write_setting(REG_MANUAL_LEVELS, 32'(w_levels));
            write_setting(REG_MANUAL_ENABLE, 32'(w_enable));

            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                // mid-phase hold-off until the result side has caught up
                if (phase == 5 && n == PHASE_TICKS / 2)
                    wait_idle();
                // time steps: mostly small, some long jumps across the period,
                // a few arbitrary timestamps
                sel = $urandom_range(0, 99);
                if (sel < 4)
                    clock_ms = $urandom;
                else if (sel < 12)
                    clock_ms += 32'($urandom_range(0, 130000));
                else if (sel < 30)
                    clock_ms += 32'($urandom_range(0, 5));
                else
                    clock_ms += 32'($urandom_range(0, 400));
                // traffic around the thresholds hits both sides of each compare
                sel = $urandom_range(0, 99);
                if (sel < 40)
                    traffic = 16'($urandom_range(0, 65535));
                else
                begin
                    near_val = int'(sel < 70 ? w_low : w_high) + int'($urandom_range(0, 4)) - 2;
                    if (near_val < 0)
                        near_val = 0;
                    if (near_val > 65535)
                        near_val = 65535;
                    traffic = 16'(near_val);
                end
                send_tick(clock_ms, traffic, 1'b0, DARK);
            end
        end

        // drain, then a few spare cycles for stray transfers
        wait_idle();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("[three_lamp_blink_mode_controller_top] OK");
        else
            $display("[three_lamp_blink_mode_controller_top] ERROR");
        $finish;
    end

endmodule
